/* hw/rtl/ddf_pkg.sv */
// shared types and constants for the display digit formatter
// used by display_digit_formatter_top and ddf_checker; no dependencies
package ddf_pkg;

	localparam int DIGIT_W = 5;
	localparam int MODE_W  = 3;

	localparam logic [DIGIT_W-1:0] CODE_BLANK = DIGIT_W'(16);

	typedef enum logic [MODE_W-1:0] {
		MODE_VALUE = 3'd0,
		MODE_TEMP  = 3'd1,
		MODE_DATE  = 3'd2,
		MODE_CODE  = 3'd3,
		MODE_ERROR = 3'd4
	} mode_t;

	// start-to-strobe latency in clock cycles
	localparam int LATENCY = 6;

endpackage

/* hw/rtl/display_digit_formatter_top.sv */
// display digit formatter: 32-bit value and mode in, five display digit codes out
// depends on ddf_pkg
//
// Takes one item in every cycle (busy is always low) and shows its five digit codes
// on digit_1..digit_5 with done high for one cycle; the result cannot be held off,
// so it must be taken when done is high. The pipeline has six stages: a reciprocal
// multiply for value mod 100000, a multiply back and a correcting subtract, then the
// decimal digits peeled over three stages (ten-thousands, thousands, then hundreds,
// tens and units together).
module display_digit_formatter_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [31:0]                 value,
	input  logic [ddf_pkg::MODE_W-1:0]  mode,
	output logic                        done,
	output logic [ddf_pkg::DIGIT_W-1:0] digit_1,
	output logic [ddf_pkg::DIGIT_W-1:0] digit_2,
	output logic [ddf_pkg::DIGIT_W-1:0] digit_3,
	output logic [ddf_pkg::DIGIT_W-1:0] digit_4,
	output logic [ddf_pkg::DIGIT_W-1:0] digit_5
);
	import ddf_pkg::*;

	// floor(2^48 / 100000): quotient estimate is low by at most one
	localparam logic [31:0] RECIP_M = 32'd2814749767;
	localparam logic [32:0] DEC_MOD = 33'd100000;

	logic accept;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [MODE_W-1:0] mode_s1, mode_s2, mode_s3, mode_s4, mode_s5;
	logic [3:0][3:0]   alt_s1, alt_s2, alt_s3, alt_s4, alt_s5;

	logic [31:0] value_s1, value_s2;
	logic [15:0] q_s1;
	logic [31:0] qd_s2;
	logic [16:0] r_s3;
	logic [3:0]  d1_s4, d1_s5, d2_s5;
	logic [13:0] rem_s4;
	logic [9:0]  rem_s5;

	logic [DIGIT_W-1:0] dig1_s6, dig2_s6, dig3_s6, dig4_s6, dig5_s6;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// splits an 8-bit field into tens and units of its value mod 100
	function automatic logic [7:0] split_mod100(input logic [7:0] x);
		logic [7:0] m;
		logic [3:0] tens;
		logic [7:0] sub;
		m = x;
		if (m >= 8'd200)
			m = m - 8'd200;
		else if (m >= 8'd100)
			m = m - 8'd100;
		tens = 4'd0;
		sub  = 8'd0;
		for (int k = 1; k < 10; k++) begin
			if (m >= 8'(k * 10)) begin
				tens = 4'(k);
				sub  = 8'(k * 10);
			end
		end
		m = m - sub;
		return {tens, m[3:0]};
	endfunction

	// stage 1: reciprocal multiply, date and hex digits
	logic [63:0]    prod;
	logic [7:0]     date_hi, date_lo;
	logic [3:0][3:0] alt_c;

	assign prod    = 64'(value) * 64'(RECIP_M);
	assign date_hi = split_mod100(value[15:8]);
	assign date_lo = split_mod100(value[7:0]);

	always_comb begin
		unique case (mode) inside
			MODE_DATE:              alt_c = {date_hi[7:4], date_hi[3:0], date_lo[7:4], date_lo[3:0]};
			MODE_CODE, MODE_ERROR:  alt_c = {value[15:12], value[11:8], value[7:4], value[3:0]};
			default:                alt_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		q_s1     <= prod[63:48];
		value_s1 <= value;
		mode_s1  <= mode;
		alt_s1   <= alt_c;
	end

	// stage 2: quotient times 100000
	logic [32:0] qd;
	assign qd = 33'(q_s1) * DEC_MOD;

	always_ff @(posedge clk) begin
		qd_s2    <= qd[31:0];
		value_s2 <= value_s1;
		mode_s2  <= mode_s1;
		alt_s2   <= alt_s1;
	end

	// stage 3: remainder with one correction
	logic [31:0] diff;
	logic [17:0] rc;
	assign diff = value_s2 - qd_s2;
	assign rc   = (diff[17:0] >= 18'd100000) ? diff[17:0] - 18'd100000 : diff[17:0];

	always_ff @(posedge clk) begin
		r_s3    <= rc[16:0];
		mode_s3 <= mode_s2;
		alt_s3  <= alt_s2;
	end

	// stage 4: ten-thousands digit
	logic [3:0]  d1_c;
	logic [16:0] sub4;
	logic [16:0] rem4;
	always_comb begin
		d1_c = 4'd0;
		sub4 = '0;
		for (int k = 1; k < 10; k++) begin
			if (r_s3 >= 17'(k * 10000)) begin
				d1_c = 4'(k);
				sub4 = 17'(k * 10000);
			end
		end
		rem4 = r_s3 - sub4;
	end

	always_ff @(posedge clk) begin
		d1_s4   <= d1_c;
		rem_s4  <= rem4[13:0];
		mode_s4 <= mode_s3;
		alt_s4  <= alt_s3;
	end

	// stage 5: thousands digit
	logic [3:0]  d2_c;
	logic [13:0] sub5;
	logic [13:0] rem5;
	always_comb begin
		d2_c = 4'd0;
		sub5 = '0;
		for (int k = 1; k < 10; k++) begin
			if (rem_s4 >= 14'(k * 1000)) begin
				d2_c = 4'(k);
				sub5 = 14'(k * 1000);
			end
		end
		rem5 = rem_s4 - sub5;
	end

	always_ff @(posedge clk) begin
		d1_s5   <= d1_s4;
		d2_s5   <= d2_c;
		rem_s5  <= rem5[9:0];
		mode_s5 <= mode_s4;
		alt_s5  <= alt_s4;
	end

	// stage 6: hundreds, tens, units and the mode select
	logic [3:0] d3_c, d4_c;
	logic [9:0] sub6a, rem6a;
	logic [6:0] sub6b, rem6b;
	logic [DIGIT_W-1:0] o1, o2, o3, o4, o5;

	always_comb begin
		d3_c  = 4'd0;
		sub6a = '0;
		for (int k = 1; k < 10; k++) begin
			if (rem_s5 >= 10'(k * 100)) begin
				d3_c  = 4'(k);
				sub6a = 10'(k * 100);
			end
		end
		rem6a = rem_s5 - sub6a;
		d4_c  = 4'd0;
		sub6b = '0;
		for (int k = 1; k < 10; k++) begin
			if (rem6a[6:0] >= 7'(k * 10)) begin
				d4_c  = 4'(k);
				sub6b = 7'(k * 10);
			end
		end
		rem6b = rem6a[6:0] - sub6b;

		unique case (mode_s5) inside
			MODE_VALUE, MODE_TEMP: begin
				o1 = DIGIT_W'(d1_s5);
				o2 = DIGIT_W'(d2_s5);
				o3 = DIGIT_W'(d3_c);
				o4 = DIGIT_W'(d4_c);
				o5 = DIGIT_W'(rem6b[3:0]);
			end
			default: begin
				o1 = '0;
				o2 = DIGIT_W'(alt_s5[3]);
				o3 = DIGIT_W'(alt_s5[2]);
				o4 = DIGIT_W'(alt_s5[1]);
				o5 = DIGIT_W'(alt_s5[0]);
			end
		endcase
		if (mode_s5 != MODE_VALUE)
			o1 = CODE_BLANK;
		if (mode_s5 == MODE_ERROR)
			o2 = CODE_BLANK;
	end

	always_ff @(posedge clk) begin
		dig1_s6 <= o1;
		dig2_s6 <= o2;
		dig3_s6 <= o3;
		dig4_s6 <= o4;
		dig5_s6 <= o5;
	end

	// valid bits travel with the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign done    = v_s6;
	assign digit_1 = dig1_s6;
	assign digit_2 = dig2_s6;
	assign digit_3 = dig3_s6;
	assign digit_4 = dig4_s6;
	assign digit_5 = dig5_s6;

endmodule

/* hw/rtl/ddf_checker.sv */
// port-level checks for display_digit_formatter_top, attached by bind
// depends on ddf_pkg
module ddf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [ddf_pkg::MODE_W-1:0]  mode,
	input logic                        done,
	input logic [ddf_pkg::DIGIT_W-1:0] digit_1,
	input logic [ddf_pkg::DIGIT_W-1:0] digit_2
);
	import ddf_pkg::*;

	// every accepted item comes out after the fixed latency
	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##6 done)
		else $error("accepted item gave no result");

	// no result without an item behind it
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("result without an accepted item");

	// place 1 is blank exactly when the mode was not value mode
	a_blank_1: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((digit_1 == CODE_BLANK) == ($past(mode, 6) != MODE_VALUE)))
		else $error("place 1 blanking does not follow mode");

	// error mode also blanks place 2, other modes never do
	a_blank_2: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((digit_2 == CODE_BLANK) == ($past(mode, 6) == MODE_ERROR)))
		else $error("place 2 blanking does not follow mode");

endmodule

bind display_digit_formatter_top ddf_checker u_ddf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.mode    (mode),
	.done    (done),
	.digit_1 (digit_1),
	.digit_2 (digit_2)
);
